[rtl/core/xysmu_pkg.sv]
// Package for the XY spin Metropolis update block: constants, command codes and
// the cosine and exponential tables. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package xysmu_pkg;

   // Lattice edge. Neighbour addressing and column tests rely on a power of two
   // whose square fits the site field.
   localparam int EDGE               = 64;
   localparam int ANGLE_BITS_DEFAULT = 16;
   localparam int SITE_W             = 12;
   localparam int FIELD_W            = 16;
   localparam int CSR_INDEX_W        = 2;
   localparam logic [16:0] LOG2E_Q16 = 17'd94548;

   typedef enum logic [1:0] {
      FUNC_LOAD    = 2'd0,
      FUNC_READ    = 2'd1,
      FUNC_PROPOSE = 2'd2,
      FUNC_SPARE   = 2'd3
   } func_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INV_TEMP  = 2'd0,
      CSR_STEP      = 2'd1,
      CSR_OPEN      = 2'd2,
      CSR_UNUSED    = 2'd3
   } csr_index_type;

   // Lattice read address selection: the site itself or one of its neighbours.
   typedef enum logic [2:0] {
      SEL_SITE  = 3'd0,
      SEL_RIGHT = 3'd1,
      SEL_LEFT  = 3'd2,
      SEL_DOWN  = 3'd3,
      SEL_UP    = 3'd4
   } nb_sel_type;

   // Datapath commands from the controller.
   typedef struct packed {
      logic       latch_item;   // capture the accepted item
      logic       rd_en;        // issue a lattice read
      nb_sel_type rd_sel;       // site or neighbour address
      logic       take_old;     // registered read data is the old spin
      logic       take_nb;      // registered read data is a neighbour spin
      logic       eval;         // compute product and acceptance
      logic       commit;       // write back or load, and form the result
   } cmd_type;

   typedef struct packed {
      logic       in_range;
      logic [1:0] func;
   } status_type;

   // round(16384*cos(j*pi/64)), j = 0..32
   function automatic logic [14:0] quarter_cos(input logic [5:0] j);
      logic [14:0] v;
      case (j)
         6'd0: v = 15'd16384;  6'd1: v = 15'd16364;  6'd2: v = 15'd16305;
         6'd3: v = 15'd16207;  6'd4: v = 15'd16069;  6'd5: v = 15'd15893;
         6'd6: v = 15'd15679;  6'd7: v = 15'd15426;  6'd8: v = 15'd15137;
         6'd9: v = 15'd14811;  6'd10: v = 15'd14449; 6'd11: v = 15'd14053;
         6'd12: v = 15'd13623; 6'd13: v = 15'd13160; 6'd14: v = 15'd12665;
         6'd15: v = 15'd12140; 6'd16: v = 15'd11585; 6'd17: v = 15'd11003;
         6'd18: v = 15'd10394; 6'd19: v = 15'd9760;  6'd20: v = 15'd9102;
         6'd21: v = 15'd8423;  6'd22: v = 15'd7723;  6'd23: v = 15'd7005;
         6'd24: v = 15'd6270;  6'd25: v = 15'd5520;  6'd26: v = 15'd4756;
         6'd27: v = 15'd3981;  6'd28: v = 15'd3196;  6'd29: v = 15'd2404;
         6'd30: v = 15'd1606;  6'd31: v = 15'd804;
         default: v = 15'd0;
      endcase
      return v;
   endfunction

   // Cosine of a 7-bit phase index in Q2.14, mirrored over the quadrants.
   function automatic logic signed [15:0] cos_q14(input logic [6:0] k);
      logic [14:0] m;
      logic [4:0]  r;
      r = k[4:0];
      case (k[6:5])
         2'd0: m = quarter_cos({1'b0, r});
         2'd1: m = quarter_cos(6'd32 - {1'b0, r});
         2'd2: m = quarter_cos({1'b0, r});
         default: m = quarter_cos(6'd32 - {1'b0, r});
      endcase
      if (k[6:5] == 2'd1 || k[6:5] == 2'd2) return -$signed({1'b0, m});
      return $signed({1'b0, m});
   endfunction

   // round(65536 * 2^(-f/16))
   function automatic logic [16:0] pow2_frac(input logic [3:0] f);
      logic [16:0] v;
      case (f)
         4'd0: v = 17'd65536;  4'd1: v = 17'd62757;  4'd2: v = 17'd60097;
         4'd3: v = 17'd57549;  4'd4: v = 17'd55109;  4'd5: v = 17'd52773;
         4'd6: v = 17'd50535;  4'd7: v = 17'd48393;  4'd8: v = 17'd46341;
         4'd9: v = 17'd44376;  4'd10: v = 17'd42495; 4'd11: v = 17'd40693;
         4'd12: v = 17'd38968; 4'd13: v = 17'd37316; 4'd14: v = 17'd35734;
         default: v = 17'd34219;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

[rtl/core/xysmu_if.sv]
// Valid/ready channel interface used by the request and response ports.
// Depends on xysmu_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface xysmu_req_if;
   import xysmu_pkg::*;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic [SITE_W-1:0]  site;
   logic [FIELD_W-1:0] angle_value;
   logic [FIELD_W-1:0] proposal_random;
   logic [FIELD_W-1:0] accept_random;
   modport source (output valid, func, site, angle_value, proposal_random,
                   accept_random, input ready);
   modport sink   (input valid, func, site, angle_value, proposal_random,
                   accept_random, output ready);
endinterface

interface xysmu_rsp_if;
   import xysmu_pkg::*;
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] spin_angle;
   logic               accepted;
   modport source (output valid, spin_angle, accepted, input ready);
   modport sink   (input valid, spin_angle, accepted, output ready);
endinterface
`default_nettype wire

[rtl/core/xysmu_ctrl.sv]
// Sequencer for the XY spin update: steps one item through lattice reads,
// evaluation and write-back, and drives the response handshake. Uses xysmu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module xysmu_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire xysmu_pkg::status_type  status,
   output xysmu_pkg::cmd_type          cmd
);
   import xysmu_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_RD0, S_RD1, S_RD2, S_RD3, S_RD4, S_LAST, S_EVAL, S_COMMIT, S_HOLD
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // A new item enters only when idle, also while a finished result still waits.
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_item = 1'b1;
               state_in       = S_RD0;
            end
         end
         S_RD0: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = SEL_SITE;
            if (status.in_range && status.func == FUNC_PROPOSE) state_in = S_RD1;
            else state_in = S_EVAL;
         end
         S_RD1: begin
            cmd.rd_en = 1'b1; cmd.rd_sel = SEL_RIGHT; cmd.take_old = 1'b1; state_in = S_RD2;
         end
         S_RD2: begin
            cmd.rd_en = 1'b1; cmd.rd_sel = SEL_LEFT; cmd.take_nb = 1'b1; state_in = S_RD3;
         end
         S_RD3: begin
            cmd.rd_en = 1'b1; cmd.rd_sel = SEL_DOWN; cmd.take_nb = 1'b1; state_in = S_RD4;
         end
         S_RD4: begin
            cmd.rd_en = 1'b1; cmd.rd_sel = SEL_UP; cmd.take_nb = 1'b1; state_in = S_LAST;
         end
         S_LAST: begin
            cmd.take_nb = 1'b1; state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (!status.in_range || status.func != FUNC_PROPOSE) cmd.take_old = 1'b1;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

[rtl/core/xysmu_dp.sv]
// Datapath of the XY spin update: lattice memory, neighbour addressing, bond
// energy accumulation and acceptance test. Uses xysmu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module xysmu_dp #(
   parameter int ANGLE_BITS = xysmu_pkg::ANGLE_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire xysmu_pkg::cmd_type            cmd,
   output xysmu_pkg::status_type              status,
   input  wire logic [1:0]                    req_func,
   input  wire logic [xysmu_pkg::SITE_W-1:0]  req_site,
   input  wire logic [xysmu_pkg::FIELD_W-1:0] req_angle_value,
   input  wire logic [xysmu_pkg::FIELD_W-1:0] req_proposal_random,
   input  wire logic [xysmu_pkg::FIELD_W-1:0] req_accept_random,
   input  wire logic [15:0]                   inv_temp,
   input  wire logic [15:0]                   step_width,
   input  wire logic                          open_boundary,
   output logic [xysmu_pkg::FIELD_W-1:0]      rsp_spin_angle,
   output logic                               rsp_accepted
);
   import xysmu_pkg::*;

   localparam int SITES  = EDGE * EDGE;
   localparam int ADDR_W = $clog2(SITES);
   localparam int CW     = $clog2(EDGE);
   localparam int SH     = 32 - ANGLE_BITS;

   logic [ANGLE_BITS-1:0] mem [SITES];

   logic [1:0]            func_ff;
   logic [ANGLE_BITS-1:0] load_ff;
   logic [15:0]           prand_ff, arand_ff;
   logic                  in_range_ff;
   logic [ADDR_W-1:0]     idx_ff;

   logic [ANGLE_BITS-1:0] rdata_ff, old_ff, new_ff;
   logic                  rvalid_ff;         // read data is a present neighbour
   logic signed [18:0]    de_ff;
   logic signed [36:0]    prod_ff;
   logic                  acc_ff;
   logic [ANGLE_BITS-1:0] out_ff;

   assign status.in_range = in_range_ff;
   assign status.func     = func_ff;

   // Neighbour address and presence.
   logic [ADDR_W-1:0] nb_addr;
   logic              nb_present;
   logic [CW-1:0]     col;
   always_comb begin
      col        = idx_ff[CW-1:0];
      nb_addr    = idx_ff;
      nb_present = 1'b1;
      case (cmd.rd_sel)
         SEL_RIGHT: begin
            nb_addr = idx_ff + ADDR_W'(1);
            if (open_boundary && col == CW'(EDGE - 1)) nb_present = 1'b0;
         end
         SEL_LEFT: begin
            nb_addr = idx_ff - ADDR_W'(1);
            if (open_boundary && col == '0) nb_present = 1'b0;
         end
         SEL_DOWN: begin
            nb_addr = idx_ff + ADDR_W'(EDGE);
            if (open_boundary && idx_ff >= ADDR_W'(SITES - EDGE)) nb_present = 1'b0;
         end
         SEL_UP: begin
            nb_addr = idx_ff - ADDR_W'(EDGE);
            if (open_boundary && idx_ff < ADDR_W'(EDGE)) nb_present = 1'b0;
         end
         default: nb_addr = idx_ff;
      endcase
   end

   // Proposal offset: floor(c*step*2^(AB-16)/2^16).
   logic signed [16:0]    centred;
   logic signed [33:0]    offs_prod;
   logic [ANGLE_BITS-1:0] offs;
   always_comb begin
      centred   = $signed({1'b0, prand_ff}) - 17'sd32768;
      offs_prod = centred * $signed({1'b0, step_width});
      offs      = ANGLE_BITS'(offs_prod >>> SH);
   end

   // Bond change for the neighbour spin in rdata_ff.
   logic [ANGLE_BITS-1:0] d_old, d_new;
   logic signed [16:0]    bond;
   always_comb begin
      d_old = old_ff - rdata_ff;
      d_new = new_ff - rdata_ff;
      bond  = 17'(cos_q14(d_old[ANGLE_BITS-1 -: 7])) - 17'(cos_q14(d_new[ANGLE_BITS-1 -: 7]));
   end

   // Acceptance threshold from the registered energy product.
   logic [54:0] y_full;
   logic [16:0] y;
   logic [16:0] thr;
   logic [12:0] n;
   always_comb begin
      y_full = 55'(prod_ff[35:0]) * 55'(LOG2E_Q16);
      y      = y_full[54:38];
      n      = y[16:4];
      thr    = (n > 13'd16) ? 17'd0 : (pow2_frac(y[3:0]) >> n[4:0]);
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_item) begin
         func_ff     <= req_func;
         load_ff     <= ANGLE_BITS'(req_angle_value);
         prand_ff    <= req_proposal_random;
         arand_ff    <= req_accept_random;
         in_range_ff <= 32'(req_site) < SITES;
         idx_ff      <= ADDR_W'(req_site);
         de_ff       <= '0;
      end
      if (cmd.rd_en) rdata_ff <= mem[nb_addr];
      rvalid_ff <= cmd.rd_en && (cmd.rd_sel != SEL_SITE) && nb_present;
      if (cmd.take_old) begin
         old_ff <= rdata_ff;
         new_ff <= rdata_ff + offs;
      end
      if (cmd.take_nb && rvalid_ff) de_ff <= de_ff + 19'(bond);
      // The full product needs 36 signed bits; both factors are widened first.
      if (cmd.eval) prod_ff <= 37'(de_ff) * 37'($signed({1'b0, inv_temp}));
      if (cmd.commit) begin
         acc_ff <= 1'b0;
         out_ff <= old_ff;
         if (in_range_ff) begin
            if (func_ff == FUNC_LOAD) begin
               mem[idx_ff] <= load_ff;
               out_ff      <= load_ff;
            end else if (func_ff == FUNC_PROPOSE) begin
               if (prod_ff <= 0 || 17'(arand_ff) < thr) begin
                  acc_ff      <= 1'b1;
                  mem[idx_ff] <= new_ff;
                  out_ff      <= new_ff;
               end
            end
         end else begin
            out_ff <= '0;
         end
      end
   end

   assign rsp_spin_angle = FIELD_W'(out_ff);
   assign rsp_accepted   = acc_ff;
endmodule
`default_nettype wire

[rtl/core/xy_spin_metropolis_update.sv]
// Top level of the XY spin Metropolis update block: configuration registers,
// sequencer and datapath. Depends on xysmu_pkg, xysmu_if, xysmu_ctrl, xysmu_dp.
//
//   Channel   Direction  Carries
//   req       in         func, site, angle_value, proposal_random, accept_random
//   rsp       out        spin_angle, accepted
//   csr       in         write enable, register index, 16-bit data
//
// A load or read reads only the site; a proposal reads the site and its four
// neighbours in turn through the single lattice memory port.
// Reset is synchronous and sets only control state and configuration registers;
// lattice contents are undefined until loaded. A result waits in its output
// register until its transfer on rsp; the next item may already be taken and
// worked on meanwhile, but its write-back stalls until that register is free.
`timescale 1ns / 1ps
`default_nettype none
module xy_spin_metropolis_update #(
   parameter int ANGLE_BITS = xysmu_pkg::ANGLE_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   xysmu_req_if.sink                              req,
   xysmu_rsp_if.source                            rsp,
   input  wire logic                              csr_we,
   input  wire logic [xysmu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [15:0]                       csr_wdata
);
   import xysmu_pkg::*;

   logic [15:0] inv_temp_ff, step_ff;
   logic        open_ff;
   cmd_type     cmd;
   status_type  status;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_temp_ff <= 16'd4096;
         step_ff     <= 16'd22938;
         open_ff     <= 1'b1;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_INV_TEMP: inv_temp_ff <= csr_wdata;
            CSR_STEP:     step_ff     <= csr_wdata;
            CSR_OPEN:     open_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   xysmu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   xysmu_dp #(.ANGLE_BITS(ANGLE_BITS)) u_dp (
      .clock               (clock),
      .cmd                 (cmd),
      .status              (status),
      .req_func            (req.func),
      .req_site            (req.site),
      .req_angle_value     (req.angle_value),
      .req_proposal_random (req.proposal_random),
      .req_accept_random   (req.accept_random),
      .inv_temp            (inv_temp_ff),
      .step_width          (step_ff),
      .open_boundary       (open_ff),
      .rsp_spin_angle      (rsp.spin_angle),
      .rsp_accepted        (rsp.accepted)
   );

   // A waiting result stays valid and unchanged until its transfer.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=>
         rsp.valid && $stable(rsp.spin_angle) && $stable(rsp.accepted))
      else $error("result changed while waiting");

   // Load and read never report acceptance.
   a_acc_only_propose: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) && status.func != FUNC_PROPOSE |-> !rsp.accepted)
      else $error("acceptance flagged for non-proposal");
endmodule
`default_nettype wire
